>>> sv/saf_pkg.sv
// shared types and constants of the sprite frame animator
// no dependencies; imported by every module of the block
package saf_pkg;

    localparam int FRAME_BITS_DEF = 16;
    localparam int CELL_BITS_DEF  = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FRAME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT   = 3'd6;

    localparam logic [15:0] RST_START_FRAME   = 16'd0;
    localparam logic [15:0] RST_END_FRAME     = 16'd0;
    localparam logic [31:0] RST_FRAME_DELAY   = 32'd65536;
    localparam logic        RST_LOOP_ENABLE   = 1'b1;
    localparam logic [12:0] RST_SHEET_COLUMNS = 13'd1;
    localparam logic [12:0] RST_CELL_WIDTH    = 13'd2;
    localparam logic [12:0] RST_CELL_HEIGHT   = 13'd2;

    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_SET_FRAME = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] elapsed;
        logic [15:0] frame_index;
    } t_in_word;

    typedef struct packed {
        logic [15:0] current_frame;
        logic [23:0] rect_left;
        logic [24:0] rect_right;
        logic [27:0] rect_top;
        logic [28:0] rect_bottom;
        logic        anim_done;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctrl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_STEP,
        S_DIV_START,
        S_DIV_WAIT,
        S_MUL,
        S_EMIT
    } t_state;

endpackage

>>> sv/saf_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on saf_pkg (t_div_ctrl)
module saf_divider #(
    parameter int FRAME_BITS = saf_pkg::FRAME_BITS_DEF,
    parameter int CELL_BITS  = saf_pkg::CELL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  saf_pkg::t_div_ctrl    i_ctrl,
    input  logic [FRAME_BITS-1:0] i_dividend,
    input  logic [CELL_BITS:0]    i_divisor,
    output saf_pkg::t_div_ctrl    o_ctrl,
    output logic [FRAME_BITS-1:0] o_quotient,
    output logic [CELL_BITS:0]    o_remainder
);
    import saf_pkg::*;

    localparam int CntW = $clog2(FRAME_BITS + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CntW-1:0]       r_cnt, n_cnt;
    logic [FRAME_BITS-1:0] r_quo, n_quo;
    logic [CELL_BITS:0]    r_rem, n_rem;
    logic [CELL_BITS:0]    r_div, n_div;
    logic [CELL_BITS+1:0]  w_shift;
    logic [CELL_BITS+1:0]  w_diff;
    logic                  w_fits;

    // shared compare/subtract step
    assign w_shift = {r_rem, r_quo[FRAME_BITS-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fits  = (w_shift >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_cnt  = CntW'(FRAME_BITS);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fits ? w_diff[CELL_BITS:0] : w_shift[CELL_BITS:0];
            n_quo = {r_quo[FRAME_BITS-2:0], w_fits};
            n_cnt = r_cnt - CntW'(1);
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_ctrl.start = 1'b0;
    assign o_ctrl.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("divider started while still busy");

endmodule

>>> sv/saf_rect.sv
// registered column and row scaling by cell size
// depends on saf_pkg for default widths
module saf_rect #(
    parameter int FRAME_BITS = saf_pkg::FRAME_BITS_DEF,
    parameter int CELL_BITS  = saf_pkg::CELL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic [CELL_BITS:0]              i_col,
    input  logic [FRAME_BITS-1:0]           i_row,
    input  logic [CELL_BITS:0]              i_cell_w,
    input  logic [CELL_BITS:0]              i_cell_h,
    output logic [2*CELL_BITS+1:0]          o_left,
    output logic [FRAME_BITS+CELL_BITS:0]   o_top
);
    import saf_pkg::*;

    logic [2*CELL_BITS+1:0]        r_left, n_left;
    logic [FRAME_BITS+CELL_BITS:0] r_top, n_top;

    always_comb begin
        n_left = r_left;
        n_top  = r_top;
        if (i_load) begin
            n_left = i_col * i_cell_w;
            n_top  = i_row * i_cell_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_top  <= n_top;
    end

    assign o_left = r_left;
    assign o_top  = r_top;

endmodule

>>> sv/sprite_frame_animator.sv
// top level of the sprite frame animator: registers, sequencer, output word
// depends on saf_pkg, saf_divider and saf_rect
//
// Steps a frame counter through start_frame..end_frame of a sprite sheet and
// reports, for every input word, the frame, its source rectangle on the sheet
// and the completion flag. A tick word adds elapsed Q16.16 time to a
// saturating timer (only when end_frame > start_frame); once the timer is
// strictly above frame_delay, the delay is taken off once and the frame
// advances, wrapping to start_frame in loop mode or holding end_frame and
// setting anim_done otherwise. A set-frame word loads the frame and clears
// anim_done; the timer is kept. A word is taken in an idle cycle; after that
// o_in_stall stays high through the update, timer step (on a tick that runs
// the timer), divide, multiply and emit steps, so no new word is taken until
// the result is in the output register. The column/row split runs on a shared
// restoring divider that produces one quotient bit per cycle; a stalled output
// register stretches the final emit step. The next word can be taken while the
// previous result still waits in the output register. Configuration is written
// through i_cfg_we / i_cfg_index / i_cfg_data; the user is to write it only
// while the block is idle, and the block itself does not enforce this.
module sprite_frame_animator #(
    parameter int FRAME_BITS = saf_pkg::FRAME_BITS_DEF,
    parameter int CELL_BITS  = saf_pkg::CELL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  saf_pkg::t_in_word                  i_in_data,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output saf_pkg::t_out_word                 o_out_data,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [saf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [saf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import saf_pkg::*;

    localparam logic [31:0] CellMax = 32'(1) << CELL_BITS;

    // configuration registers
    logic [15:0] r_start_frame;
    logic [15:0] r_end_frame;
    logic [31:0] r_frame_delay;
    logic        r_loop_enable;
    logic [12:0] r_sheet_columns;
    logic [12:0] r_cell_width;
    logic [12:0] r_cell_height;

    // animation state
    t_state                r_state, n_state;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [31:0]           r_acc, n_acc;
    logic                  r_done, n_done;

    // captured input word and output register
    t_in_word              r_item, n_item;
    t_out_word             r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic                  w_in_take;
    logic                  w_out_free;
    logic                  w_rect_load;
    t_div_ctrl             w_div_req;
    t_div_ctrl             w_div_rsp;
    logic [FRAME_BITS-1:0] w_quotient;
    logic [CELL_BITS:0]    w_remainder;
    logic [CELL_BITS:0]    w_cols, w_cw, w_ch;
    logic [2*CELL_BITS+1:0]        w_left;
    logic [FRAME_BITS+CELL_BITS:0] w_top;
    logic [63:0]           w_left64, w_top64;
    logic [32:0]           w_sum;
    logic [32:0]           w_slack;
    logic [FRAME_BITS:0]   w_next;
    logic                  w_out_of_range;

    // zero reads as one, above 2^CELL_BITS reads as 2^CELL_BITS
    function automatic logic [CELL_BITS:0] geom_clamp(input logic [12:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) begin
            return (CELL_BITS+1)'(1);
        end else if (v32 > CellMax) begin
            return (CELL_BITS+1)'(CellMax);
        end
        return (CELL_BITS+1)'(v32);
    endfunction

    assign w_cols = geom_clamp(r_sheet_columns);
    assign w_cw   = geom_clamp(r_cell_width);
    assign w_ch   = geom_clamp(r_cell_height);

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // saturating timer add and delay compare
    assign w_sum   = {1'b0, r_acc} + {1'b0, r_item.elapsed};
    assign w_slack = {1'b0, r_frame_delay} - {1'b0, r_acc};

    // next frame, compared at full width so a carry out counts as above range
    assign w_next = {1'b0, r_frame} + (FRAME_BITS+1)'(1);
    assign w_out_of_range = w_next[FRAME_BITS]
                         || (33'(w_next) < 33'(r_start_frame))
                         || (33'(w_next) > 33'(r_end_frame));

    assign w_left64 = 64'(w_left);
    assign w_top64  = 64'(w_top);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_frame     = r_frame;
        n_acc       = r_acc;
        n_done      = r_done;
        n_item      = r_item;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_div_req   = '0;
        w_rect_load = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_item  = i_in_data;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (r_item.operation == OP_SET_FRAME) begin
                    n_frame = FRAME_BITS'(r_item.frame_index);
                    n_done  = 1'b0;
                    n_state = S_DIV_START;
                end else if (r_end_frame > r_start_frame) begin
                    n_acc   = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
                    n_state = S_STEP;
                end else begin
                    n_state = S_DIV_START;
                end
            end
            S_STEP: begin
                // borrow means the timer is strictly above the delay
                if (w_slack[32]) begin
                    n_acc = r_acc - r_frame_delay;
                    if (!w_out_of_range) begin
                        n_frame = w_next[FRAME_BITS-1:0];
                    end else if (r_loop_enable) begin
                        n_frame = FRAME_BITS'(r_start_frame);
                    end else begin
                        n_frame = FRAME_BITS'(r_end_frame);
                        n_done  = 1'b1;
                    end
                end
                n_state = S_DIV_START;
            end
            S_DIV_START: begin
                w_div_req.start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                w_rect_load = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.current_frame = 16'(r_frame);
                    n_out.rect_left     = w_left64[23:0];
                    n_out.rect_right    = 25'(w_left64 + 64'(w_cw));
                    n_out.rect_top      = w_top64[27:0];
                    n_out.rect_bottom   = 29'(w_top64 + 64'(w_ch));
                    n_out.anim_done     = r_done;
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frame     <= '0;
            r_acc       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame     <= n_frame;
            r_acc       <= n_acc;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_frame   <= RST_START_FRAME;
            r_end_frame     <= RST_END_FRAME;
            r_frame_delay   <= RST_FRAME_DELAY;
            r_loop_enable   <= RST_LOOP_ENABLE;
            r_sheet_columns <= RST_SHEET_COLUMNS;
            r_cell_width    <= RST_CELL_WIDTH;
            r_cell_height   <= RST_CELL_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_FRAME:   r_start_frame   <= i_cfg_data[15:0];
                CFG_END_FRAME:     r_end_frame     <= i_cfg_data[15:0];
                CFG_FRAME_DELAY:   r_frame_delay   <= i_cfg_data[31:0];
                CFG_LOOP_ENABLE:   r_loop_enable   <= i_cfg_data[0];
                CFG_SHEET_COLUMNS: r_sheet_columns <= i_cfg_data[12:0];
                CFG_CELL_WIDTH:    r_cell_width    <= i_cfg_data[12:0];
                CFG_CELL_HEIGHT:   r_cell_height   <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    // frame div / mod columns
    saf_divider #(
        .FRAME_BITS (FRAME_BITS),
        .CELL_BITS  (CELL_BITS)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_div_req),
        .i_dividend  (r_frame),
        .i_divisor   (w_cols),
        .o_ctrl      (w_div_rsp),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder)
    );

    // scale column and row to pixels
    saf_rect #(
        .FRAME_BITS (FRAME_BITS),
        .CELL_BITS  (CELL_BITS)
    ) u_rect (
        .i_clk    (i_clk),
        .i_load   (w_rect_load),
        .i_col    (w_remainder),
        .i_row    (w_quotient),
        .i_cell_w (w_cw),
        .i_cell_h (w_ch),
        .o_left   (w_left),
        .o_top    (w_top)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_take_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == S_UPDATE))
        else $error("accepted word did not start an update");

    a_emit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not placed in the output register");

    a_done_only_on_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(r_state) == S_STEP && !$past(r_loop_enable)))
        else $error("completion flag set outside a clamped frame step");

    a_frame_moves_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DIV_WAIT || r_state == S_EMIT) |=> $stable(r_frame))
        else $error("frame changed outside the update steps");

endmodule
